/* design/iirdf1_pkg.sv */
package iirdf1_pkg;

   // sample, tap and output width
   localparam int DATA_W = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // stored tap counts, independent of the configured orders
   localparam int FF_TAPS = 5;
   localparam int FB_TAPS = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FF_TAPS_0_1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_TAPS_2_3 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_TAP_4    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_TAPS_0_1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_TAPS_2_3 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_TAPS_4_5 = 3'd5;

   // per-cell control
   typedef struct packed {
      logic load;
      logic rotate;
   } cell_ctrl_type;

endpackage

/* design/iirdf1_cell.sv */
module iirdf1_cell import iirdf1_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [DATA_W-1:0] nbr_data,
   input  logic [DATA_W-1:0] load_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // load wins over rotation, otherwise hold
   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.rotate) begin
         data_in = nbr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

/* design/iirdf1_mac.sv */
module iirdf1_mac import iirdf1_pkg::*; (
   input  logic              clock,
   input  logic              clear,
   input  logic              enable,
   input  logic [DATA_W-1:0] operand,
   input  logic [DATA_W-1:0] tap,
   output logic [DATA_W-1:0] acc
);

   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;
   logic [DATA_W-1:0] prod_low;

   // low half of the product, everything wraps mod 2^32
   assign prod_low = operand * tap;

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (enable) begin
         acc_in = acc_ff + prod_low;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* design/iir_filter_direct_form_one_top.sv */
// a producing sample runs through ST_MAC, where the ring of cells rotates once past one shared
// MAC, then ST_DONE, which waits while an earlier result is still unaccepted and then registers
// its result; a filling sample goes from ST_IDLE straight to ST_DONE; a new sample is taken only
// in ST_IDLE, after the last one has left ST_DONE; the output register lets the next sample in
// while a result waits
// reset: synchronous, clears taps, input window, output history and fill count
module iir_filter_direct_form_one_top import iirdf1_pkg::*; #(
   parameter int FEEDFORWARD_ORDER = 4,
   parameter int FEEDBACK_ORDER    = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,    // [31:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,    // [31:0] filtered
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NT     = FEEDFORWARD_ORDER + 1 + FEEDBACK_ORDER;
   localparam int CNT_W  = $clog2(NT);
   localparam int FILL_W = $clog2(FEEDFORWARD_ORDER + 1);
   localparam logic [CNT_W-1:0]  LAST_TERM = CNT_W'(NT - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FEEDFORWARD_ORDER);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MAC  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              produce_ff, produce_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0] ff_tap_ff [FF_TAPS];
   logic [DATA_W-1:0] fb_tap_ff [FB_TAPS];

   logic              accept;
   logic              advance;
   logic [DATA_W-1:0] mac_acc;
   logic [DATA_W-1:0] cell_q    [NT];
   logic [DATA_W-1:0] load_d    [NT];
   logic [DATA_W-1:0] term_tap  [NT];
   cell_ctrl_type     cell_ctrl [NT];

   // handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign advance    = (state_ff == ST_DONE) &&
                       (!produce_ff || !rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // tap registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FF_TAPS; i++) ff_tap_ff[i] <= '0;
         for (int i = 0; i < FB_TAPS; i++) fb_tap_ff[i] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FF_TAPS_0_1: begin
               ff_tap_ff[0] <= csr_wdata[31:0];
               ff_tap_ff[1] <= csr_wdata[63:32];
            end
            CSR_FF_TAPS_2_3: begin
               ff_tap_ff[2] <= csr_wdata[31:0];
               ff_tap_ff[3] <= csr_wdata[63:32];
            end
            CSR_FF_TAP_4: begin
               ff_tap_ff[4] <= csr_wdata[31:0];
            end
            CSR_FB_TAPS_0_1: begin
               fb_tap_ff[0] <= csr_wdata[31:0];
               fb_tap_ff[1] <= csr_wdata[63:32];
            end
            CSR_FB_TAPS_2_3: begin
               fb_tap_ff[2] <= csr_wdata[31:0];
               fb_tap_ff[3] <= csr_wdata[63:32];
            end
            CSR_FB_TAPS_4_5: begin
               fb_tap_ff[4] <= csr_wdata[31:0];
               fb_tap_ff[5] <= csr_wdata[63:32];
            end
            default: begin
            end
         endcase
      end
   end

   // ring of cells: window (oldest first), new sample, history (latest first)
   for (genvar p = 0; p < NT; p++) begin : g_ring
      if (p < FEEDFORWARD_ORDER) begin : g_win
         assign load_d[p]        = cell_q[p+1];
         assign cell_ctrl[p].load = advance;
         assign term_tap[p]      = ff_tap_ff[p];
      end else if (p == FEEDFORWARD_ORDER) begin : g_new
         assign load_d[p]        = req_tdata;
         assign cell_ctrl[p].load = accept;
         assign term_tap[p]      = ff_tap_ff[p];
      end else if (p == FEEDFORWARD_ORDER + 1) begin : g_hist0
         assign load_d[p]        = mac_acc;
         assign cell_ctrl[p].load = advance & produce_ff;
         assign term_tap[p]      = fb_tap_ff[p-FEEDFORWARD_ORDER-1];
      end else begin : g_hist
         assign load_d[p]        = cell_q[p-1];
         assign cell_ctrl[p].load = advance & produce_ff;
         assign term_tap[p]      = fb_tap_ff[p-FEEDFORWARD_ORDER-1];
      end
      assign cell_ctrl[p].rotate = (state_ff == ST_MAC);

      iirdf1_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl[p]),
         .nbr_data  (cell_q[(p+1) % NT]),
         .load_data (load_d[p]),
         .data      (cell_q[p])
      );
   end

   // shared multiply-accumulate on the head of the ring
   iirdf1_mac u_mac (
      .clock   (clock),
      .clear   (accept),
      .enable  (state_ff == ST_MAC),
      .operand (cell_q[0]),
      .tap     (term_tap[cnt_ff]),
      .acc     (mac_acc)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      produce_in   = produce_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               produce_in = (fill_ff == FILL_FULL);
               cnt_in     = '0;
               state_in   = (fill_ff == FILL_FULL) ? ST_MAC : ST_DONE;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_TERM) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (advance) begin
               state_in = ST_IDLE;
               if (produce_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = mac_acc;
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         produce_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         produce_ff   <= produce_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
